>>> sv/rgb_to_yuv_planar_chroma_subsample_unit_macros.svh
// assertion macros used by the checker file
`ifndef RGB_TO_YUV_PLANAR_CHROMA_SUBSAMPLE_UNIT_MACROS_SVH
`define RGB_TO_YUV_PLANAR_CHROMA_SUBSAMPLE_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define RYC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every clock edge, reset included
`define RYC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/ryc_pkg.sv
`default_nettype none

package ryc_pkg;

   // field widths
   localparam int CFG_W     = 12;
   localparam int ADDR_W    = 22;
   localparam int SAMPLE_W  = 8;
   localparam int CSR_IDX_W = 2;
   localparam int ACC_W     = 27;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PIC_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIC_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHROMA_MODE = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] PIC_WIDTH_RESET  = 12'd720;
   localparam logic [CFG_W-1:0] PIC_HEIGHT_RESET = 12'd400;

   // chroma layouts
   localparam logic [1:0] CHROMA_420 = 2'd0;
   localparam logic [1:0] CHROMA_422 = 2'd1;
   localparam logic [1:0] CHROMA_444 = 2'd2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // q16 conversion coefficients
   localparam logic signed [17:0] COEF_Y_R = 18'sd19595;
   localparam logic signed [17:0] COEF_Y_G = 18'sd38470;
   localparam logic signed [17:0] COEF_Y_B = 18'sd7471;
   localparam logic signed [17:0] COEF_U_R = -18'sd11058;
   localparam logic signed [17:0] COEF_U_G = -18'sd21710;
   localparam logic signed [17:0] COEF_U_B = 18'sd32768;
   localparam logic signed [17:0] COEF_V_R = 18'sd32768;
   localparam logic signed [17:0] COEF_V_G = -18'sd27439;
   localparam logic signed [17:0] COEF_V_B = -18'sd5329;
   localparam logic signed [ACC_W-1:0] OFFSET_Y  = 27'sd0;
   localparam logic signed [ACC_W-1:0] OFFSET_UV = 27'sd8355840;

   // target planes, in emission order
   typedef enum logic [1:0] {
      PLANE_Y = 2'd0,
      PLANE_U = 2'd1,
      PLANE_V = 2'd2
   } plane_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [1:0]          plane_select;
      logic [ADDR_W-1:0]   plane_address;
      logic [SAMPLE_W-1:0] sample_value;
      logic                pixel_done;
      logic                frame_done;
   } rsp_type;

   // one classified pixel waiting for the back end
   typedef struct packed {
      req_type           pixel;
      logic [ADDR_W-1:0] luma_address;
      logic [ADDR_W-1:0] chroma_address;
      logic              chroma_on;
      logic              frame_end;
   } work_type;

endpackage

`default_nettype wire

>>> sv/ryc_front.sv
`default_nettype none

module ryc_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [ryc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ryc_pkg::CFG_W-1:0]      csr_data,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire ryc_pkg::req_type               req_word,
   output logic                                q_push,
   output ryc_pkg::work_type                   q_word,
   input  wire logic                           q_full
);
   import ryc_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int SWN = $clog2(MAX_WIDTH + 16) + 1;
   localparam int DW  = (SWN > CFG_W) ? SWN : CFG_W;
   localparam int HWN = $clog2(MAX_HEIGHT) + 1;
   localparam int HW  = (HWN > CFG_W) ? HWN : CFG_W;
   localparam logic [DW-1:0] W_LIMIT = DW'(MAX_WIDTH);
   localparam logic [HW-1:0] H_LIMIT = HW'(MAX_HEIGHT);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [1:0]       mode_ff, mode_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;

   logic [DW-1:0]     w_ext, w_eff, stride, half_stride, col_next;
   logic [HW-1:0]     h_ext, h_eff, row_next;
   logic              last_col, last_row;
   logic [RW-1:0]     chroma_row;
   logic [ADDR_W-1:0] luma_addr, chroma_addr;
   logic              chroma_on;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PIC_WIDTH:   width_in  = csr_data;
            CSR_PIC_HEIGHT:  height_in = csr_data;
            CSR_CHROMA_MODE: mode_in   = csr_data[1:0];
            default: ;
         endcase
      end
   end

   // effective frame size and strides
   always_comb begin
      w_ext       = DW'(width_ff);
      h_ext       = HW'(height_ff);
      w_eff       = (width_ff == '0) ? DW'(1) : ((w_ext > W_LIMIT) ? W_LIMIT : w_ext);
      h_eff       = (height_ff == '0) ? HW'(1) : ((h_ext > H_LIMIT) ? H_LIMIT : h_ext);
      stride      = (w_eff + DW'(15)) & ~DW'(15);
      half_stride = stride >> 1;
      col_next    = DW'(col_ff) + DW'(1);
      row_next    = HW'(row_ff) + HW'(1);
      last_col    = (col_next >= w_eff);
      last_row    = (row_next >= h_eff);
   end

   // plane addresses and chroma decision
   always_comb begin
      luma_addr  = ADDR_W'(col_ff) + ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(stride));
      chroma_row = (mode_ff == CHROMA_420) ? (row_ff >> 1) : row_ff;
      unique case (mode_ff)
         CHROMA_444: begin
            chroma_on   = 1'b1;
            chroma_addr = luma_addr;
         end
         CHROMA_420: begin
            chroma_on   = ~col_ff[0] & ~row_ff[0];
            chroma_addr = ADDR_W'(col_ff >> 1)
                        + ADDR_W'(ADDR_W'(chroma_row) * ADDR_W'(half_stride));
         end
         default: begin
            chroma_on   = ~col_ff[0];
            chroma_addr = ADDR_W'(col_ff >> 1)
                        + ADDR_W'(ADDR_W'(chroma_row) * ADDR_W'(half_stride));
         end
      endcase
   end

   // hand the classified word to the queue
   assign req_full = q_full;
   assign q_push   = req_push & ~q_full;

   always_comb begin
      q_word.pixel          = req_word;
      q_word.luma_address   = luma_addr;
      q_word.chroma_address = chroma_addr;
      q_word.chroma_on      = chroma_on;
      q_word.frame_end      = last_col & last_row;
   end

   // raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (q_push) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : RW'(row_next);
         end else begin
            col_in = CW'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= PIC_WIDTH_RESET;
         height_ff <= PIC_HEIGHT_RESET;
         mode_ff   <= CHROMA_420;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/ryc_queue.sv
`default_nettype none

module ryc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ryc_pkg::work_type  push_word,
   output logic                    full,
   input  wire logic               pop,
   output ryc_pkg::work_type       pop_word,
   output logic                    empty
);
   import ryc_pkg::*;

   work_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   // occupancy
   assign full     = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_word = entries_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

>>> sv/ryc_back.sv
`default_nettype none

module ryc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ryc_pkg::work_type  q_word,
   input  wire logic               q_empty,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output ryc_pkg::rsp_type        rsp_word
);
   import ryc_pkg::*;

   work_type  work_ff, work_in;
   logic      work_valid_ff, work_valid_in;
   plane_type phase_ff, phase_in;
   rsp_type   out_ff, out_in;
   logic      out_valid_ff, out_valid_in;

   logic                    out_free, emit, last_phase, work_free;
   logic signed [17:0]      coef_r, coef_g, coef_b;
   logic signed [ACC_W-1:0] offset, red_ext, green_ext, blue_ext, acc;
   logic [SAMPLE_W-1:0]     sample;

   // handshake between work slot and output register
   assign out_free   = ~out_valid_ff | rsp_pop;
   assign emit       = work_valid_ff & out_free;
   assign last_phase = (phase_ff == PLANE_V) | ((phase_ff == PLANE_Y) & ~work_ff.chroma_on);
   assign work_free  = ~work_valid_ff | (emit & last_phase);
   assign q_pop      = work_free & ~q_empty;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (q_pop) begin
         phase_in = PLANE_Y;
      end else if (emit) begin
         unique case (phase_ff)
            PLANE_Y: phase_in = PLANE_U;
            PLANE_U: phase_in = PLANE_V;
            default: phase_in = PLANE_Y;
         endcase
      end
   end

   // coefficient set for the current plane
   always_comb begin
      unique case (phase_ff)
         PLANE_Y: begin
            coef_r = COEF_Y_R;
            coef_g = COEF_Y_G;
            coef_b = COEF_Y_B;
            offset = OFFSET_Y;
         end
         PLANE_U: begin
            coef_r = COEF_U_R;
            coef_g = COEF_U_G;
            coef_b = COEF_U_B;
            offset = OFFSET_UV;
         end
         default: begin
            coef_r = COEF_V_R;
            coef_g = COEF_V_G;
            coef_b = COEF_V_B;
            offset = OFFSET_UV;
         end
      endcase
   end

   // q16 dot product, floor and saturate
   always_comb begin
      red_ext   = ACC_W'($signed({1'b0, work_ff.pixel.red}));
      green_ext = ACC_W'($signed({1'b0, work_ff.pixel.green}));
      blue_ext  = ACC_W'($signed({1'b0, work_ff.pixel.blue}));
      acc = offset + ACC_W'(coef_r) * red_ext + ACC_W'(coef_g) * green_ext
          + ACC_W'(coef_b) * blue_ext;
      if (acc[ACC_W-1]) begin
         sample = '0;
      end else if (|acc[ACC_W-2:16+SAMPLE_W]) begin
         sample = '1;
      end else begin
         sample = acc[16+SAMPLE_W-1:16];
      end
   end

   // outputs of the sequencer
   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      if (q_pop) begin
         work_in       = q_word;
         work_valid_in = 1'b1;
      end else if (emit && last_phase) begin
         work_valid_in = 1'b0;
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in.plane_select  = phase_ff;
         out_in.plane_address = (phase_ff == PLANE_Y) ? work_ff.luma_address
                                                      : work_ff.chroma_address;
         out_in.sample_value  = sample;
         out_in.pixel_done    = last_phase;
         out_in.frame_done    = last_phase & work_ff.frame_end;
         out_valid_in         = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PLANE_Y;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      out_ff  <= out_in;
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp_word  = out_ff;

endmodule

`default_nettype wire

>>> sv/rgb_to_yuv_planar_chroma_subsample_unit.sv
// a pixel pushed into an idle unit passes the queue, the work slot and the result register
// before its Y word shows; U and V follow in turn as the word before each is popped
// the back end emits one plane word per cycle on the single result port while work waits and
// the sink pops; a pixel that carries chroma gives three words, a luma-only pixel one
// reset: synchronous, clears position counters, queue and result register; 720x400, 4:2:0
`default_nettype none

module rgb_to_yuv_planar_chroma_subsample_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [ryc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ryc_pkg::CFG_W-1:0]      csr_data,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire ryc_pkg::req_type               req_word,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output ryc_pkg::rsp_type                    rsp_word
);
   import ryc_pkg::*;

   logic     q_push, q_full, q_pop, q_empty;
   work_type q_push_word, q_pop_word;

   // position tracking and address generation
   ryc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .q_push    (q_push),
      .q_word    (q_push_word),
      .q_full    (q_full)
   );

   // decoupling queue
   ryc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_push_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_word  (q_pop_word),
      .empty     (q_empty)
   );

   // color conversion and plane word sequencing
   ryc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_word    (q_pop_word),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

>>> sv/ryc_checker.sv
`default_nettype none

`include "rgb_to_yuv_planar_chroma_subsample_unit_macros.svh"

module ryc_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           rsp_empty,
   input  wire logic                           rsp_pop,
   input  wire ryc_pkg::rsp_type               rsp_word
);
   import ryc_pkg::*;

   // result side comes up empty
   `RYC_ASSERT_ALWAYS(a_reset_empty, reset |=> rsp_empty, "result not empty after reset")

   // a word left waiting stays put
   `RYC_ASSERT(a_hold, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_word), "waiting word changed")

   // frame end only on the last word of a pixel
   `RYC_ASSERT(a_frame_pixel, !rsp_empty && rsp_word.frame_done |-> rsp_word.pixel_done, "frame_done without pixel_done")

   // V word is ready right after its U word is taken
   `RYC_ASSERT(a_u_then_v, !rsp_empty && rsp_pop && rsp_word.plane_select == PLANE_U |=> !rsp_empty && rsp_word.plane_select == PLANE_V, "V word missing after U")

endmodule

bind rgb_to_yuv_planar_chroma_subsample_unit ryc_checker u_checker (.*);

`default_nettype wire

>>> sim/rgb_to_yuv_planar_chroma_subsample_unit_tb.sv
`timescale 1ns / 1ps

module rgb_to_yuv_planar_chroma_subsample_unit_tb;
   import ryc_pkg::*;

   localparam int MAX_W = 2048;
   localparam int MAX_H = 2048;
   localparam int RANDOM_PIXELS = 395;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;

   // index past the last register, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   // chroma code with no layout of its own
   localparam logic [1:0] CHROMA_SPARE = 2'd3;

   typedef enum logic {ROW_CSR, ROW_PIXEL} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [1:0]       index;
      logic [CFG_W-1:0] data;
      req_type          pixel;
      bit               pinned;
      logic [2:0][7:0]  pin;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_word = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_word;

   // predictor copy of the registers and the raster position
   int width_reg = int'(PIC_WIDTH_RESET);
   int height_reg = int'(PIC_HEIGHT_RESET);
   logic [1:0] mode_reg = CHROMA_420;
   int col_pos = 0;
   int row_pos = 0;

   rsp_type plane_writes[$];
   stim_row_type directed_rows[$];
   rsp_type oldest_write;
   int mismatch_count = 0;
   int idle_cycles = 0;
   int sink_hold = 0;
   bit sender_gaps = 1'b0;
   bit sink_stalls = 1'b0;
   int random_pixels = 0;

   always #10 clock = ~clock;

   rgb_to_yuv_planar_chroma_subsample_unit #(
      .MAX_WIDTH(MAX_W),
      .MAX_HEIGHT(MAX_H)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_push(req_push),
      .req_full(req_full),
      .req_word(req_word),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_word(rsp_word)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int clip_dim(input int v, input int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // floor of a q16 sum, clamped to a byte
   function automatic logic [7:0] sat_q16(input int acc);
      if (acc < 0) return 8'd0;
      acc = acc >>> 16;
      if (acc > 255) return 8'd255;
      return acc[7:0];
   endfunction

   // convert one pixel, queue its plane words and step the raster position
   function automatic void place_pixel(input req_type px, input bit pinned,
                                       input logic [2:0][7:0] pin);
      int r, g, b, w, h, stride;
      logic [2:0][7:0] smp;
      logic [ADDR_W-1:0] luma_a, chroma_a;
      bit chroma_on, last_col, last_row;
      rsp_type word;
      r = int'(px.red);
      g = int'(px.green);
      b = int'(px.blue);
      w = clip_dim(width_reg, MAX_W);
      h = clip_dim(height_reg, MAX_H);
      stride = (w + 15) & ~15;
      smp[PLANE_Y] = sat_q16(19595 * r + 38470 * g + 7471 * b);
      smp[PLANE_U] = sat_q16(8355840 - 11058 * r - 21710 * g + 32768 * b);
      smp[PLANE_V] = sat_q16(8355840 + 32768 * r - 27439 * g - 5329 * b);
      if (pinned) smp = pin;
      luma_a = ADDR_W'(col_pos + row_pos * stride);
      case (mode_reg)
         CHROMA_444: begin
            chroma_on = 1'b1;
            chroma_a = luma_a;
         end
         CHROMA_420: begin
            chroma_on = (col_pos % 2 == 0) && (row_pos % 2 == 0);
            chroma_a = ADDR_W'((col_pos >> 1) + (row_pos >> 1) * (stride >> 1));
         end
         default: begin
            chroma_on = (col_pos % 2 == 0);
            chroma_a = ADDR_W'((col_pos >> 1) + row_pos * (stride >> 1));
         end
      endcase
      last_col = (col_pos + 1 >= w);
      last_row = (row_pos + 1 >= h);

      word.plane_select = PLANE_Y;
      word.plane_address = luma_a;
      word.sample_value = smp[PLANE_Y];
      word.pixel_done = !chroma_on;
      word.frame_done = !chroma_on && last_col && last_row;
      plane_writes.push_back(word);
      if (chroma_on) begin
         word.plane_select = PLANE_U;
         word.plane_address = chroma_a;
         word.sample_value = smp[PLANE_U];
         word.pixel_done = 1'b0;
         word.frame_done = 1'b0;
         plane_writes.push_back(word);
         word.plane_select = PLANE_V;
         word.sample_value = smp[PLANE_V];
         word.pixel_done = 1'b1;
         word.frame_done = last_col && last_row;
         plane_writes.push_back(word);
      end

      // raster advance, wrapping at the frame end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   function automatic void csr_row(input logic [1:0] index, input logic [CFG_W-1:0] data);
      stim_row_type row;
      row.kind = ROW_CSR;
      row.index = index;
      row.data = data;
      row.pixel = '0;
      row.pinned = 1'b0;
      row.pin = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void pixel_row(input req_type px, input bit pinned,
                                     input logic [7:0] y, input logic [7:0] u,
                                     input logic [7:0] v);
      stim_row_type row;
      row.kind = ROW_PIXEL;
      row.index = '0;
      row.data = '0;
      row.pixel = px;
      row.pinned = pinned;
      row.pin = {v, u, y};
      directed_rows.push_back(row);
   endfunction

   // channels biased toward the extremes
   function automatic req_type random_pixel();
      logic [2:0][7:0] ch;
      int roll;
      for (int k = 0; k < 3; k++) begin
         roll = $urandom_range(0, 9);
         ch[k] = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom);
      end
      return ch;
   endfunction

   function automatic logic [CFG_W-1:0] pick_width();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 2) return 12'd2048;
      if (roll == 2) return 12'd0;
      if (roll == 3) return 12'hFFF;
      if (roll == 4) return 12'd1;
      return 12'($urandom_range(2, 40));
   endfunction

   function automatic logic [CFG_W-1:0] pick_height();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 2) return 12'd1;
      if (roll == 2) return 12'd0;
      if (roll == 3) return 12'hFFF;
      if (roll == 4) return 12'd2048;
      return 12'($urandom_range(2, 6));
   endfunction

   // let the unit run dry before touching the registers
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (plane_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_PIC_WIDTH: width_reg = int'(data);
         CSR_PIC_HEIGHT: height_reg = int'(data);
         CSR_CHROMA_MODE: mode_reg = data[1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(input req_type px, input bit pinned, input logic [2:0][7:0] pin);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_word <= px;
      do @(posedge clock); while (req_full);
      place_pixel(px, pinned, pin);
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%s: expected plane %0d addr %0d sample %0d pd %0b fd %0b, got plane %0d addr %0d sample %0d pd %0b fd %0b",
                  what, want.plane_select, want.plane_address, want.sample_value,
                  want.pixel_done, want.frame_done, got.plane_select, got.plane_address,
                  got.sample_value, got.pixel_done, got.frame_done);
   endtask

   // result sink with random stalls
   always @(negedge clock) begin
      if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         if (sink_stalls) sink_hold <= pick_gap();
      end
   end

   // compare each popped word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (plane_writes.size() == 0) begin
            note_mismatch("unexpected word", '0, rsp_word);
         end else begin
            oldest_write = plane_writes.pop_front();
            if (rsp_word.plane_select !== oldest_write.plane_select
                || rsp_word.plane_address !== oldest_write.plane_address
                || rsp_word.sample_value !== oldest_write.sample_value
                || rsp_word.pixel_done !== oldest_write.pixel_done
                || rsp_word.frame_done !== oldest_write.frame_done)
               note_mismatch("mismatch", oldest_write, rsp_word);
         end
      end
   end

   // watchdog on cycles where no handshake completes
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int n;
      // reset state, origin gets all three planes, next column luma only
      pixel_row({8'd0, 8'd0, 8'd0}, 1'b1, 8'd0, 8'd127, 8'd127);
      pixel_row({8'd255, 8'd255, 8'd255}, 1'b1, 8'd255, 8'd127, 8'd127);
      // tiny 3x2 frame in 4:4:4, entered mid-row, plus a dropped write
      csr_row(CSR_PIC_WIDTH, 12'd3);
      csr_row(CSR_PIC_HEIGHT, 12'd2);
      csr_row(CSR_CHROMA_MODE, CFG_W'(CHROMA_444));
      csr_row(CSR_UNUSED, 12'hFFF);
      pixel_row({8'd255, 8'd0, 8'd0}, 1'b1, 8'd76, 8'd84, 8'd255);
      pixel_row({8'd0, 8'd255, 8'd0}, 1'b1, 8'd149, 8'd43, 8'd20);
      pixel_row({8'd0, 8'd0, 8'd255}, 1'b1, 8'd29, 8'd255, 8'd106);
      pixel_row({8'd255, 8'd255, 8'd255}, 1'b1, 8'd255, 8'd127, 8'd127);
      // zero width and oversized height in 4:2:2
      csr_row(CSR_CHROMA_MODE, CFG_W'(CHROMA_422));
      csr_row(CSR_PIC_WIDTH, 12'd0);
      csr_row(CSR_PIC_HEIGHT, 12'hFFF);
      repeat (3) pixel_row(random_pixel(), 1'b0, 8'd0, 8'd0, 8'd0);
      // spare chroma code, oversized width, rows now past the last one
      csr_row(CSR_CHROMA_MODE, CFG_W'(CHROMA_SPARE));
      csr_row(CSR_PIC_WIDTH, 12'hFFF);
      csr_row(CSR_PIC_HEIGHT, 12'd1);
      pixel_row({8'd0, 8'd0, 8'd0}, 1'b1, 8'd0, 8'd127, 8'd127);
      pixel_row(random_pixel(), 1'b0, 8'd0, 8'd0, 8'd0);
      // 1x1 frame, every pixel ends a frame
      csr_row(CSR_CHROMA_MODE, CFG_W'(CHROMA_420));
      csr_row(CSR_PIC_WIDTH, 12'd1);
      csr_row(CSR_PIC_HEIGHT, 12'd1);
      repeat (2) pixel_row(random_pixel(), 1'b0, 8'd0, 8'd0, 8'd0);
      // largest frame
      csr_row(CSR_PIC_WIDTH, 12'd2048);
      csr_row(CSR_PIC_HEIGHT, 12'd2048);
      pixel_row({8'd255, 8'd255, 8'd255}, 1'b1, 8'd255, 8'd127, 8'd127);
      pixel_row(random_pixel(), 1'b0, 8'd0, 8'd0, 8'd0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle();
            write_csr(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_pixel(directed_rows[i].pixel, directed_rows[i].pinned, directed_rows[i].pin);
         end
      end

      // random phases, registers rewritten between them while idle
      while (random_pixels < RANDOM_PIXELS) begin
         settle();
         sender_gaps = ($urandom_range(0, 3) != 0);
         sink_stalls = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) != 0) write_csr(CSR_PIC_WIDTH, pick_width());
         if ($urandom_range(0, 3) != 0) write_csr(CSR_PIC_HEIGHT, pick_height());
         if ($urandom_range(0, 2) != 0)
            write_csr(CSR_CHROMA_MODE, CFG_W'($urandom_range(0, 3)));
         if ($urandom_range(0, 7) == 0) write_csr(CSR_UNUSED, 12'($urandom));
         n = $urandom_range(10, 50);
         if (n > RANDOM_PIXELS - random_pixels) n = RANDOM_PIXELS - random_pixels;
         repeat (n) send_pixel(random_pixel(), 1'b0, '0);
         random_pixels += n;
      end

      settle();
      if (mismatch_count == 0 && plane_writes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
